// ----- design/bze_pkg.sv -----
// Shared types, constants and codes for the cubic Bezier easing evaluator.
package bze_pkg;

	localparam int DEF_FRAC_BITS = 16;
	localparam int X_W           = 17;
	localparam int BYTE_W        = 8;
	localparam int LIMIT_W       = 4;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd12;

	localparam int NORM_DIV  = 127;
	localparam int NORM_HALF = 63;
	// n / 127 == (n * RECIP_M) >> RECIP_S for every n below 16644
	localparam int RECIP_M   = 16514;
	localparam int RECIP_S   = 21;

	typedef enum logic [4:0] {
		S_IDLE,
		S_N0,
		S_N1,
		S_N2,
		S_N3,
		S_KSET,
		S_LT2,
		S_LT3,
		S_LM0,
		S_LM1,
		S_LM2,
		S_LUPD,
		S_FT2,
		S_FT3,
		S_FR2,
		S_FA1,
		S_FA2,
		S_FB1,
		S_FB2,
		S_FY,
		S_DONE
	} bze_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_NORM,
		OP_KSET,
		OP_T2,
		OP_T3,
		OP_M0,
		OP_M1,
		OP_M2,
		OP_UPD,
		OP_FT2,
		OP_R2,
		OP_A1,
		OP_A2,
		OP_B1,
		OP_B2,
		OP_YSUM,
		OP_EMIT
	} bze_op_t;

	typedef enum logic [1:0] {
		COEF_P1X,
		COEF_P2X,
		COEF_P1Y,
		COEF_P2Y
	} bze_coef_t;

	typedef struct packed {
		bze_op_t   op;
		bze_coef_t coef;
	} bze_cmd_t;

	typedef struct packed {
		logic bypass;
		logic limit_zero;
		logic f_zero;
		logic last_step;
		logic out_free;
	} bze_status_t;

endpackage

// ----- design/bze_in_if.sv -----
// Input channel: progress value and raw control-point bytes.
interface bze_in_if;
	import bze_pkg::*;

	logic              valid;
	logic              ready;
	logic [X_W-1:0]    x_in;
	logic [BYTE_W-1:0] p1_x_byte;
	logic [BYTE_W-1:0] p1_y_byte;
	logic [BYTE_W-1:0] p2_x_byte;
	logic [BYTE_W-1:0] p2_y_byte;

	modport source (
		output valid, x_in, p1_x_byte, p1_y_byte, p2_x_byte, p2_y_byte,
		input  ready
	);
	modport sink (
		input  valid, x_in, p1_x_byte, p1_y_byte, p2_x_byte, p2_y_byte,
		output ready
	);
endinterface

// ----- design/bze_out_if.sv -----
// Output channel: eased value with bypass flag and step count.
interface bze_out_if;
	import bze_pkg::*;

	logic               valid;
	logic               ready;
	logic [X_W-1:0]     y_out;
	logic               linear_bypass;
	logic [LIMIT_W-1:0] steps_taken;

	modport source (
		output valid, y_out, linear_bypass, steps_taken,
		input  ready
	);
	modport sink (
		input  valid, y_out, linear_bypass, steps_taken,
		output ready
	);
endinterface

// ----- design/bze_ctrl.sv -----
// Sequencer that steps the shared-multiplier datapath through one evaluation.
module bze_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bze_pkg::bze_status_t  status,
	output bze_pkg::bze_cmd_t     cmd
);
	import bze_pkg::*;

	bze_state_t state_q;
	bze_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_N0;
			end
			S_N0: begin
				state_d = status.bypass ? S_DONE : S_N1;
			end
			S_N1:   state_d = S_N2;
			S_N2:   state_d = S_N3;
			S_N3:   state_d = S_KSET;
			S_KSET: begin
				state_d = status.limit_zero ? S_FT2 : S_LT2;
			end
			S_LT2:  state_d = S_LT3;
			S_LT3:  state_d = S_LM0;
			S_LM0:  state_d = S_LM1;
			S_LM1:  state_d = S_LM2;
			S_LM2:  state_d = S_LUPD;
			S_LUPD: begin
				if (status.f_zero || status.last_step) state_d = S_FT2;
				else state_d = S_LT2;
			end
			S_FT2:  state_d = S_FT3;
			S_FT3:  state_d = S_FR2;
			S_FR2:  state_d = S_FA1;
			S_FA1:  state_d = S_FA2;
			S_FA2:  state_d = S_FB1;
			S_FB1:  state_d = S_FB2;
			S_FB2:  state_d = S_FY;
			S_FY:   state_d = S_DONE;
			S_DONE: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.op   = OP_NONE;
		cmd.coef = COEF_P1X;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_N0: begin
				cmd.op   = OP_NORM;
				cmd.coef = COEF_P1X;
			end
			S_N1: begin
				cmd.op   = OP_NORM;
				cmd.coef = COEF_P2X;
			end
			S_N2: begin
				cmd.op   = OP_NORM;
				cmd.coef = COEF_P1Y;
			end
			S_N3: begin
				cmd.op   = OP_NORM;
				cmd.coef = COEF_P2Y;
			end
			S_KSET: cmd.op = OP_KSET;
			S_LT2:  cmd.op = OP_T2;
			S_LT3:  cmd.op = OP_T3;
			S_LM0:  cmd.op = OP_M0;
			S_LM1:  cmd.op = OP_M1;
			S_LM2:  cmd.op = OP_M2;
			S_LUPD: cmd.op = OP_UPD;
			S_FT2:  cmd.op = OP_FT2;
			S_FT3:  cmd.op = OP_T3;
			S_FR2:  cmd.op = OP_R2;
			S_FA1:  cmd.op = OP_A1;
			S_FA2:  cmd.op = OP_A2;
			S_FB1:  cmd.op = OP_B1;
			S_FB2:  cmd.op = OP_B2;
			S_FY:   cmd.op = OP_YSUM;
			S_DONE: begin
				if (status.out_free) cmd.op = OP_EMIT;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ----- design/bze_dp.sv -----
// Datapath: operand registers, one shared fixed-point multiplier, output register.
module bze_dp #(
	parameter int FRAC_BITS = bze_pkg::DEF_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bze_pkg::bze_cmd_t            cmd,
	output bze_pkg::bze_status_t         status,
	input  logic                         cfg_we,
	input  logic [bze_pkg::LIMIT_W-1:0]  cfg_wdata,
	input  logic [bze_pkg::X_W-1:0]      x_in,
	input  logic [bze_pkg::BYTE_W-1:0]   p1_x_byte,
	input  logic [bze_pkg::BYTE_W-1:0]   p1_y_byte,
	input  logic [bze_pkg::BYTE_W-1:0]   p2_x_byte,
	input  logic [bze_pkg::BYTE_W-1:0]   p2_y_byte,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [bze_pkg::X_W-1:0]      y_out,
	output logic                         linear_bypass,
	output logic [bze_pkg::LIMIT_W-1:0]  steps_taken
);
	import bze_pkg::*;

	localparam int XW    = FRAC_BITS + 1;
	localparam int AW    = FRAC_BITS + 4;
	localparam int FW    = FRAC_BITS + 6;
	localparam int PW    = AW - 1 + XW;
	localparam int CW    = (XW > X_W) ? XW : X_W;
	localparam int ONE_I = 1 << FRAC_BITS;
	localparam int NQ    = ONE_I / NORM_DIV;
	localparam int NR    = ONE_I % NORM_DIV;
	localparam logic [XW-1:0] ONE = XW'(ONE_I);

	function automatic logic [6:0] clamp_byte(input logic [BYTE_W-1:0] b);
		return b[7] ? 7'(NORM_DIV) : b[6:0];
	endfunction

	logic [XW-1:0]        x_q;
	logic [6:0]           b1x_q, b1y_q, b2x_q, b2y_q;
	logic                 bypass_q;
	logic [XW-1:0]        p1x_q, p1y_q, p2x_q, p2y_q;
	logic signed [AW-1:0] k0_q, k1_q, k2_q;
	logic [XW-1:0]        t_q, t2_q, t3_q, r_q, r2_q, y_q;
	logic signed [AW-1:0] m_q;
	logic signed [FW-1:0] f_q;
	logic [AW-1:0]        acc_q;
	logic [LIMIT_W-1:0]   steps_q;
	logic [LIMIT_W-1:0]   limit_q;
	logic                 out_valid_q;
	logic [X_W-1:0]       y_out_q;
	logic                 bypass_out_q;
	logic [LIMIT_W-1:0]   steps_out_q;

	logic [6:0]           c1x, c1y, c2x, c2y;
	logic [XW-1:0]        x_clamp;
	logic [6:0]           nv;
	logic [13:0]          nn;
	logic [28:0]          nprod;
	logic [XW-1:0]        norm_val;
	logic signed [AW-1:0] ep1, ep2, one_s;
	logic signed [AW-1:0] a_sel;
	logic [XW-1:0]        b_sel;
	logic signed [AW-1:0] a_abs;
	logic [PW-1:0]        prod;
	logic [AW-1:0]        pq;
	logic signed [AW-1:0] mul_res;
	logic [XW-1:0]        mul_u;
	logic signed [FW-1:0] m_ext, x_ext, f_sum, f_adj, f_half;
	logic signed [FW:0]   t_new;
	logic [XW-1:0]        t_clamp;
	logic [AW-1:0]        m3;
	logic [AW-1:0]        y_sum;
	logic [XW-1:0]        y_clamp;

	// input conditioning
	always_comb begin
		c1x = clamp_byte(p1_x_byte);
		c1y = clamp_byte(p1_y_byte);
		c2x = clamp_byte(p2_x_byte);
		c2y = clamp_byte(p2_y_byte);
		x_clamp = (CW'(x_in) > CW'(ONE)) ? ONE : XW'(x_in);
	end

	// byte to fraction: round(v * ONE / 127) split into v*NQ + (v*NR + 63) / 127
	always_comb begin
		unique case (cmd.coef)
			COEF_P1X: nv = b1x_q;
			COEF_P2X: nv = b2x_q;
			COEF_P1Y: nv = b1y_q;
			COEF_P2Y: nv = b2y_q;
			default:  nv = b1x_q;
		endcase
		nn       = 14'(nv) * 14'(NR) + 14'(NORM_HALF);
		nprod    = 29'(nn) * 29'(RECIP_M);
		norm_val = XW'(nv) * XW'(NQ) + XW'(nprod[28:RECIP_S]);
	end

	// coefficients
	always_comb begin
		ep1   = $signed({{(AW-XW){1'b0}}, p1x_q});
		ep2   = $signed({{(AW-XW){1'b0}}, p2x_q});
		one_s = $signed({{(AW-XW){1'b0}}, ONE});
	end

	// shared multiplier, magnitude truncated, b operand never negative
	always_comb begin
		unique case (cmd.op)
			OP_T2, OP_FT2, OP_B1: a_sel = $signed({{(AW-XW){1'b0}}, t_q});
			OP_T3, OP_A1:         a_sel = $signed({{(AW-XW){1'b0}}, t2_q});
			OP_M0:                a_sel = k0_q;
			OP_M1:                a_sel = k1_q;
			OP_M2:                a_sel = k2_q;
			OP_R2:                a_sel = $signed({{(AW-XW){1'b0}}, r_q});
			OP_A2, OP_B2:         a_sel = m_q;
			default:              a_sel = '0;
		endcase
		unique case (cmd.op)
			OP_T2, OP_FT2, OP_T3, OP_M2: b_sel = t_q;
			OP_M0:                       b_sel = t3_q;
			OP_M1:                       b_sel = t2_q;
			OP_R2, OP_A1:                b_sel = r_q;
			OP_A2:                       b_sel = p2y_q;
			OP_B1:                       b_sel = r2_q;
			OP_B2:                       b_sel = p1y_q;
			default:                     b_sel = '0;
		endcase
		a_abs   = a_sel[AW-1] ? -a_sel : a_sel;
		prod    = PW'(a_abs[AW-2:0]) * PW'(b_sel);
		pq      = prod[PW-1:FRAC_BITS];
		mul_res = a_sel[AW-1] ? -$signed(pq) : $signed(pq);
		mul_u   = mul_res[XW-1:0];
	end

	// residual and relaxation step
	always_comb begin
		m_ext  = $signed({{(FW-AW){m_q[AW-1]}}, m_q});
		x_ext  = $signed({{(FW-XW){1'b0}}, x_q});
		f_sum  = f_q + m_ext;
		f_adj  = f_sum + $signed({{(FW-1){1'b0}}, f_sum[FW-1]});
		f_half = f_adj >>> 1;
		t_new  = $signed({{(FW+1-XW){1'b0}}, t_q}) - $signed({f_half[FW-1], f_half});
		if (t_new[FW]) begin
			t_clamp = '0;
		end else if (t_new > $signed({{(FW+1-XW){1'b0}}, ONE})) begin
			t_clamp = ONE;
		end else begin
			t_clamp = t_new[XW-1:0];
		end
	end

	// final sum, terms are non-negative here
	always_comb begin
		m3      = AW'({m_q[AW-2:0], 1'b0}) + AW'(m_q);
		y_sum   = acc_q + m3;
		y_clamp = (y_sum > AW'(ONE)) ? ONE : y_sum[XW-1:0];
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				x_q      <= x_clamp;
				b1x_q    <= c1x;
				b1y_q    <= c1y;
				b2x_q    <= c2x;
				b2y_q    <= c2y;
				bypass_q <= (c1x == c1y) && (c2x == c2y);
				steps_q  <= '0;
			end
			OP_NORM: begin
				unique case (cmd.coef)
					COEF_P1X: p1x_q <= norm_val;
					COEF_P2X: p2x_q <= norm_val;
					COEF_P1Y: p1y_q <= norm_val;
					COEF_P2Y: p2y_q <= norm_val;
					default:  p1x_q <= norm_val;
				endcase
			end
			OP_KSET: begin
				k0_q <= one_s + (ep1 <<< 1) + ep1 - (ep2 <<< 1) - ep2;
				k1_q <= (ep2 <<< 1) + ep2 - (ep1 <<< 2) - (ep1 <<< 1);
				k2_q <= (ep1 <<< 1) + ep1;
				t_q  <= x_q;
			end
			OP_T2:  t2_q <= mul_u;
			OP_FT2: begin
				t2_q <= mul_u;
				r_q  <= ONE - t_q;
			end
			OP_T3:  t3_q <= mul_u;
			OP_M0:  m_q  <= mul_res;
			OP_M1: begin
				m_q <= mul_res;
				f_q <= m_ext - x_ext;
			end
			OP_M2: begin
				m_q <= mul_res;
				f_q <= f_sum;
			end
			OP_UPD: begin
				if (f_sum != '0) begin
					t_q     <= t_clamp;
					steps_q <= steps_q + 1'b1;
				end
			end
			OP_R2:  r2_q <= mul_u;
			OP_A1, OP_A2, OP_B2: m_q <= mul_res;
			OP_B1: begin
				m_q   <= mul_res;
				acc_q <= AW'(t3_q) + m3;
			end
			OP_YSUM: y_q <= y_clamp;
			OP_EMIT: begin
				y_out_q      <= bypass_q ? X_W'(x_q) : X_W'(y_q);
				bypass_out_q <= bypass_q;
				steps_out_q  <= steps_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= LIMIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (cmd.op == OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		status.bypass     = bypass_q;
		status.limit_zero = (limit_q == '0);
		status.f_zero     = (f_sum == '0);
		status.last_step  = ((LIMIT_W+1)'(steps_q) + 1'b1) == (LIMIT_W+1)'(limit_q);
		status.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid     = out_valid_q;
	assign y_out         = y_out_q;
	assign linear_bypass = bypass_out_q;
	assign steps_taken   = steps_out_q;

endmodule

// ----- design/bezier_easing_evaluator.sv -----
// Top level of the cubic Bezier easing evaluator (y from x).
// One transaction is evaluated at a time on a single shared fixed-point
// multiplier that does one product per cycle. A transaction normalises the
// control points, runs at most iteration_limit relaxation passes (12 after
// reset; steps_taken counts those that moved t) and then evaluates y; an
// identity curve goes straight to the result. The input is taken again once
// the result has moved into the output register, which holds it until the
// sink takes it. iteration_limit is meant to be written through cfg_we/cfg_wdata
// only while no transaction is in flight; the block itself does not enforce this.
module bezier_easing_evaluator #(
	parameter int FRAC_BITS = bze_pkg::DEF_FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bze_in_if.sink                      sample,
	bze_out_if.source                   result,
	input  logic                        cfg_we,
	input  logic [bze_pkg::LIMIT_W-1:0] cfg_wdata
);
	import bze_pkg::*;

	bze_cmd_t    cmd;
	bze_status_t status;

	bze_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.status   (status),
		.cmd      (cmd)
	);

	bze_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.x_in          (sample.x_in),
		.p1_x_byte     (sample.p1_x_byte),
		.p1_y_byte     (sample.p1_y_byte),
		.p2_x_byte     (sample.p2_x_byte),
		.p2_y_byte     (sample.p2_y_byte),
		.out_ready     (result.ready),
		.out_valid     (result.valid),
		.y_out         (result.y_out),
		.linear_bypass (result.linear_bypass),
		.steps_taken   (result.steps_taken)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> !sample.ready)
		else $error("second transaction accepted while one is in flight");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> (!result.valid || result.ready))
		else $error("result register overwritten while still pending");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.op == OP_EMIT))
		else $error("result appeared without an emit command");

	a_bypass_steps: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.linear_bypass |-> result.steps_taken == '0)
		else $error("identity result reports relaxation steps");

endmodule
